FILE: rtl/stkrm_pkg.sv
// ----------------------------------------------------------------------------
// stkrm_pkg
// Shared widths, sizes and operation codes of the stack with search and remove.
// ----------------------------------------------------------------------------
package stkrm_pkg;

	// storage geometry
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	// derived widths
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// transaction field widths
	localparam int OP_W    = 3;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH     = 3'd0;
	localparam logic [OP_W-1:0] OP_POP      = 3'd1;
	localparam logic [OP_W-1:0] OP_CONTAINS = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE   = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

endpackage

FILE: rtl/stkrm_req_if.sv
// ----------------------------------------------------------------------------
// stkrm_req_if
// Request channel: one operation and its value per transaction.
// ----------------------------------------------------------------------------
interface stkrm_req_if import stkrm_pkg::*; ();

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [VALUE_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);

endinterface

FILE: rtl/stkrm_rsp_if.sv
// ----------------------------------------------------------------------------
// stkrm_rsp_if
// Response channel: success flag and entry count per transaction.
// ----------------------------------------------------------------------------
interface stkrm_rsp_if import stkrm_pkg::*; ();

	logic               valid;
	logic               ready;
	logic               success;
	logic [COUNT_W-1:0] count;

	modport source (output valid, output success, output count, input ready);
	modport sink   (input valid, input success, input count, output ready);

endinterface

FILE: rtl/stack_with_remove_by_value_unit.sv
// ----------------------------------------------------------------------------
// stack_with_remove_by_value_unit
// Bounded stack with push, pop, contains, remove by value and clear.
// ----------------------------------------------------------------------------
// The entries live in a single-port-write, registered-read memory of DEPTH
// words; the count and the control state sit in flip-flops. Every request
// transaction yields exactly one response transaction. Push, pop, clear and
// unknown codes go from idle straight to the response state; the response
// is registered from there once the output register is free. Contains and
// remove walk the memory from the top down, one entry per cycle through the
// memory read port, visiting at most DEPTH entries; a successful remove
// then reads the top entry and copies it over the match. A new request is
// taken once the previous one has its response in the output register,
// even if that response has not yet been taken downstream; the block
// returns to idle in the same cycle that the response is registered.
module stack_with_remove_by_value_unit import stkrm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	stkrm_req_if.sink    req,
	stkrm_rsp_if.source  rsp
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_TOP  = 2'd2;
	localparam logic [1:0] ST_RESP = 2'd3;

	// entry storage
	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rdata_q;

	logic [1:0]            state_q, state_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic [IDX_W-1:0]      cur_q, cur_d;
	logic [DATA_WIDTH-1:0] val_q, val_d;
	logic                  is_remove_q, is_remove_d;
	logic                  res_q, res_d;

	logic                  rsp_valid_q;
	logic                  rsp_success_q;
	logic [COUNT_W-1:0]    rsp_count_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_raddr;

	logic                  rsp_free;
	logic                  accept;
	logic [IDX_W-1:0]      top_idx;
	logic [DATA_WIDTH-1:0] in_val;

	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign top_idx   = IDX_W'(cnt_q - CNT_W'(1));
	assign in_val    = DATA_WIDTH'(req.value);

	// control and memory access sequencing
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cur_d       = cur_q;
		val_d       = val_q;
		is_remove_d = is_remove_q;
		res_d       = res_q;
		mem_we      = 1'b0;
		mem_waddr   = cnt_q[IDX_W-1:0];
		mem_wdata   = in_val;
		mem_re      = 1'b0;
		mem_raddr   = top_idx;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					val_d       = in_val;
					is_remove_d = (req.operation == OP_REMOVE);
					res_d       = 1'b0;
					state_d     = ST_RESP;
					case (req.operation)
						OP_PUSH: begin
							if (cnt_q < CNT_W'(DEPTH)) begin
								mem_we = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
								res_d  = 1'b1;
							end
						end
						OP_POP: begin
							if (cnt_q != '0) begin
								cnt_d = cnt_q - CNT_W'(1);
								res_d = 1'b1;
							end
						end
						OP_CONTAINS, OP_REMOVE: begin
							if (cnt_q != '0) begin
								mem_re  = 1'b1;
								cur_d   = top_idx;
								state_d = ST_SCAN;
							end
						end
						OP_CLEAR: begin
							cnt_d = '0;
							res_d = 1'b1;
						end
						default: begin
							res_d = 1'b0;
						end
					endcase
				end
			end
			ST_SCAN: begin
				// rdata_q holds the entry at cur_q
				if (rdata_q == val_q) begin
					if (is_remove_q) begin
						mem_re  = 1'b1;
						state_d = ST_TOP;
					end else begin
						res_d   = 1'b1;
						state_d = ST_RESP;
					end
				end else if (cur_q == '0) begin
					res_d   = 1'b0;
					state_d = ST_RESP;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cur_q - IDX_W'(1);
					cur_d     = cur_q - IDX_W'(1);
				end
			end
			ST_TOP: begin
				// copy the top entry over the match, then drop the top
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = rdata_q;
				cnt_d     = cnt_q - CNT_W'(1);
				res_d     = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// per-operation payload
	always_ff @(posedge clk) begin
		cur_q       <= cur_d;
		val_q       <= val_d;
		is_remove_q <= is_remove_d;
		res_q       <= res_d;
	end

	// response output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && rsp_free) begin
			rsp_success_q <= res_q;
			rsp_count_q   <= COUNT_W'(cnt_q);
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.success = rsp_success_q;
	assign rsp.count   = rsp_count_q;

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stack with search and remove by value. A queue
// of requests (directed corner cases, then random push/search/remove/drain
// sequences) is driven in bursts with gaps. The receiver stalls on a pattern
// of its own and once holds off long enough to back up the input. A shadow
// stack predicts every response, and each response is checked field by field.
// ----------------------------------------------------------------------------
module testbench;
	import stkrm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// codes the block does not define
	localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
	localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 200;
	localparam int DRAIN_CYCLES = DEPTH + 8;
	localparam int TIMEOUT_NS   = 5_000_000;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [VALUE_W-1:0] value;
	} stk_req_t;

	typedef struct packed {
		logic               success;
		logic [COUNT_W-1:0] count;
	} stk_result_t;

	typedef enum logic [1:0] {RX_STREAM, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;
	typedef enum logic [1:0] {SEQ_FILL, SEQ_MIX, SEQ_DRAIN, SEQ_NOISE} seq_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	stkrm_req_if req_ch ();
	stkrm_rsp_if rsp_ch ();

	stack_with_remove_by_value_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// stimulus and expectations
	stk_req_t            pending_reqs [$];
	stk_result_t         expected_results [$];
	logic [VALUE_W-1:0]  recent_values [$];
	int                  n_req_accepted = 0;
	int                  n_rsp_checked  = 0;
	int                  n_errors       = 0;
	int                  n_defined_ops  = 0;

	// shadow stack
	logic [DATA_WIDTH-1:0] shadow_mem [DEPTH];
	int unsigned           shadow_count = 0;
	int                    n_full_push  = 0;
	int                    n_search_hit = 0;
	int                    n_remove_hit = 0;
	int                    max_depth    = 0;

	// next shadow state and response for one request
	function automatic stk_result_t apply_stack_op(stk_req_t r);
		logic [DATA_WIDTH-1:0] v;
		int                    pos;
		stk_result_t           res;
		v = r.value[DATA_WIDTH-1:0];
		pos = -1;
		res.success = 1'b0;
		if (r.op == OP_CONTAINS || r.op == OP_REMOVE) begin
			for (int i = int'(shadow_count) - 1; i >= 0 && pos < 0; i--) begin
				if (shadow_mem[i] == v)
					pos = i;
			end
		end
		case (r.op)
			OP_PUSH: begin
				if (shadow_count < DEPTH) begin
					shadow_mem[shadow_count] = v;
					shadow_count++;
					res.success = 1'b1;
				end else begin
					n_full_push++;
				end
			end
			OP_POP: begin
				if (shadow_count > 0) begin
					shadow_count--;
					res.success = 1'b1;
				end
			end
			OP_CONTAINS: begin
				res.success = (pos >= 0);
				if (pos >= 0)
					n_search_hit++;
			end
			OP_REMOVE: begin
				if (pos >= 0) begin
					shadow_mem[pos] = shadow_mem[shadow_count - 1];
					shadow_count--;
					res.success = 1'b1;
					n_remove_hit++;
				end
			end
			OP_CLEAR: begin
				shadow_count = 0;
				res.success = 1'b1;
			end
			default: begin
			end
		endcase
		if (int'(shadow_count) > max_depth)
			max_depth = int'(shadow_count);
		res.count = COUNT_W'(shadow_count);
		return res;
	endfunction

	task automatic queue_item(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value);
		stk_req_t r;
		r.op = op;
		r.value = value;
		pending_reqs.push_back(r);
		if (op <= OP_CLEAR)
			n_defined_ops++;
		if (op == OP_PUSH) begin
			recent_values.push_back(value);
			if (recent_values.size() > 24)
				void'(recent_values.pop_front());
		end
	endtask

	// mostly values that are likely stored, some small, some wide
	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6 && recent_values.size() > 0)
			return recent_values[$urandom_range(0, recent_values.size() - 1)];
		else if (r < 8)
			return $urandom_range(0, 3);
		else
			return $urandom();
	endfunction

	function automatic logic [VALUE_W-1:0] push_value();
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 7);
		else
			return $urandom();
	endfunction

	// driver state
	stk_req_t drv_cur;
	logic     drv_have_item = 1'b0;
	int       drv_seen_acc  = 0;
	int       drv_burst     = 1;
	int       drv_gap       = 0;

	// request driver: bursts of transactions with random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else begin
			if (drv_have_item && n_req_accepted != drv_seen_acc) begin
				drv_seen_acc = n_req_accepted;
				drv_have_item = 1'b0;
				if (drv_burst > 0)
					drv_burst--;
				if (drv_burst == 0) begin
					drv_burst = $urandom_range(1, 24);
					drv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (!drv_have_item) begin
				if (drv_gap > 0)
					drv_gap--;
				else if (pending_reqs.size() > 0) begin
					drv_cur = pending_reqs.pop_front();
					drv_have_item = 1'b1;
				end
			end
			req_ch.valid     <= drv_have_item;
			req_ch.operation <= drv_cur.op;
			req_ch.value     <= drv_have_item ? drv_cur.value : VALUE_W'($urandom());
		end
	end

	// receiver state
	rx_mode_t rx_mode      = RX_STREAM;
	int       rx_mode_left = 0;
	int       rx_phase     = 0;
	int       rx_hold_left = 0;
	logic     rx_hold_done = 1'b0;

	// response ready: changing stall patterns plus one long hold-off
	always @(negedge clk) begin
		logic rdy;
		if (!arst_n) begin
			rdy = 1'b0;
		end else begin
			if (!rx_hold_done && n_req_accepted >= HOLD_AT) begin
				rx_hold_left = HOLD_CYCLES;
				rx_hold_done = 1'b1;
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				rdy = 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = rx_mode_t'($urandom_range(0, 3));
					rx_mode_left = $urandom_range(20, 120);
				end
				rx_mode_left--;
				rx_phase++;
				case (rx_mode)
					RX_STREAM:   rdy = 1'b1;
					RX_HALF:     rdy = 1'($urandom_range(0, 1));
					RX_SPARSE:   rdy = ($urandom_range(0, 3) == 0);
					RX_PERIODIC: rdy = ((rx_phase % 5) < 2);
					default:     rdy = 1'b1;
				endcase
			end
		end
		rsp_ch.ready <= rdy;
	end

	// monitor: check responses, then predict newly accepted requests
	always @(posedge clk) begin
		stk_result_t got;
		stk_result_t want;
		stk_req_t    seen;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.success = rsp_ch.success;
				got.count = rsp_ch.count;
				n_rsp_checked++;
				if (expected_results.size() == 0) begin
					$error("unexpected response transaction: success=%0d count=%0d",
						got.success, got.count);
					n_errors++;
				end else begin
					want = expected_results.pop_front();
					if (got.success !== want.success) begin
						$error("success: expected %0d, actual %0d", want.success, got.success);
						n_errors++;
					end
					if (got.count !== want.count) begin
						$error("count: expected %0d, actual %0d", want.count, got.count);
						n_errors++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen.op = req_ch.operation;
				seen.value = req_ch.value;
				expected_results.push_back(apply_stack_op(seen));
				n_req_accepted++;
			end
		end
	end

	// run limit
	initial begin
		#(TIMEOUT_NS);
		$display("[stack_with_remove_by_value_unit] ERROR");
		$finish;
	end

	// stimulus, reset and end of run
	initial begin
		seq_kind_t kind;
		int        n;
		int        r;

		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.operation = OP_PUSH;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// directed corner cases
		queue_item(OP_RSVD_5, 32'hFFFF_FFFF);
		queue_item(OP_POP, 32'h0);                // pop on empty
		queue_item(OP_CONTAINS, 32'h0);           // search on empty
		queue_item(OP_REMOVE, 32'h0);             // remove on empty
		queue_item(OP_PUSH, 32'h0);
		queue_item(OP_PUSH, 32'hFFFF_FFFF);
		queue_item(OP_CONTAINS, 32'h0);           // hit at the bottom
		queue_item(OP_CONTAINS, 32'h1);           // absent value
		queue_item(OP_REMOVE, 32'hFFFF_FFFF);     // remove of the top itself
		queue_item(OP_REMOVE, 32'h1234_5678);     // absent value
		queue_item(OP_PUSH, 32'h5);
		queue_item(OP_PUSH, 32'h9);
		queue_item(OP_PUSH, 32'h5);
		queue_item(OP_REMOVE, 32'h5);             // topmost of two equal entries
		queue_item(OP_PUSH, 32'h7);
		queue_item(OP_REMOVE, 32'h0);             // bottom overwritten by top
		queue_item(OP_CONTAINS, 32'h5);
		queue_item(OP_POP, 32'hA5A5_A5A5);
		queue_item(OP_RSVD_6, 32'h0);
		queue_item(OP_CLEAR, 32'hFFFF_FFFF);
		queue_item(OP_CONTAINS, 32'h9);           // search after clear
		queue_item(OP_RSVD_7, 32'h0);
		queue_item(OP_POP, 32'h0);

		// random sequences
		n_defined_ops = 0;
		while (n_defined_ops < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			kind = (r < 25) ? SEQ_FILL : (r < 70) ? SEQ_MIX : (r < 95) ? SEQ_DRAIN : SEQ_NOISE;
			case (kind)
				SEQ_FILL: begin
					if ($urandom_range(0, 1) == 0)
						queue_item(OP_CLEAR, $urandom());
					n = $urandom_range(14, 18);
					repeat (n) queue_item(OP_PUSH, push_value());
					n = $urandom_range(4, 8);
					repeat (n) queue_item($urandom_range(0, 1) ? OP_CONTAINS : OP_REMOVE,
						pick_value());
				end
				SEQ_MIX: begin
					repeat (20) begin
						r = $urandom_range(0, 99);
						if (r < 35)
							queue_item(OP_PUSH, push_value());
						else if (r < 45)
							queue_item(OP_POP, $urandom());
						else if (r < 68)
							queue_item(OP_CONTAINS, pick_value());
						else if (r < 93)
							queue_item(OP_REMOVE, pick_value());
						else if (r < 96)
							queue_item(OP_CLEAR, $urandom());
						else
							queue_item(OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7)), $urandom());
					end
				end
				SEQ_DRAIN: begin
					n = $urandom_range(10, 20);
					repeat (n) queue_item($urandom_range(0, 1) ? OP_POP : OP_REMOVE,
						pick_value());
				end
				default: begin
					n = $urandom_range(1, 3);
					repeat (n) queue_item(OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7)),
						$urandom());
				end
			endcase
		end

		// reset, released away from both clock edges
		repeat (8) @(posedge clk);
		#5 arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !drv_have_item);
		wait (expected_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("requests accepted: %0d, responses checked: %0d, deepest stack: %0d",
			n_req_accepted, n_rsp_checked, max_depth);
		$display("pushes refused when full: %0d, search hits: %0d, removals: %0d",
			n_full_push, n_search_hit, n_remove_hit);
		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("[stack_with_remove_by_value_unit] OK");
		end else begin
			$display("[stack_with_remove_by_value_unit] ERROR");
		end
		$finish;
	end

endmodule
